/* design/kwlex_pkg.sv */
package kwlex_pkg;

  localparam int unsigned POSITION_WIDTH = 32;
  localparam int unsigned LENGTH_WIDTH   = 16;

  // record packing on the master side
  localparam int unsigned REC_BITS  = 4 + 2 + POSITION_WIDTH + LENGTH_WIDTH;
  localparam int unsigned REC_BYTES = (REC_BITS + 7) / 8;
  localparam int unsigned OUT_TDATA_WIDTH = REC_BYTES * 8;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KIND_LPAREN  = 4'd0,
    KIND_RPAREN  = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_SLASH   = 4'd4,
    KIND_STAR    = 4'd5,
    KIND_NUMBER  = 4'd6,
    KIND_IDENT   = 4'd7,
    KIND_KEYWORD = 4'd8,
    KIND_STRING  = 4'd9,
    KIND_EOF     = 4'd10,
    KIND_UNTERM  = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    KW_DO   = 2'd0,
    KW_END  = 2'd1,
    KW_FUNC = 2'd2,
    KW_EXIT = 2'd3
  } kw_e;

  // first letters of a run, earliest letter most significant
  localparam logic [31:0] PREFIX_DO   = 32'h0000_646F;
  localparam logic [31:0] PREFIX_END  = 32'h0065_6E64;
  localparam logic [31:0] PREFIX_FUNC = 32'h6675_6E63;
  localparam logic [31:0] PREFIX_EXIT = 32'h6578_6974;

  typedef struct packed {
    mode_e                     mode;
    logic [POSITION_WIDTH-1:0] pos;
    logic [POSITION_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0]   count;
    logic [31:0]               prefix;
  } scan_state_t;

  typedef struct packed {
    logic                      last;
    logic [LENGTH_WIDTH-1:0]   len;
    logic [POSITION_WIDTH-1:0] start;
    kw_e                       kw;
    kind_e                     kind;
  } token_rec_t;

endpackage

/* design/keyword_token_lexer.sv */
// Streaming tokenizer: source bytes in, token records out.
// Slave side: one source byte per beat in s_axis_tdata; s_axis_tlast marks
// end of input (the data byte of that beat is ignored). Master side: one
// token record per beat in m_axis_tdata (kind, keyword code, start offset,
// length), m_axis_tlast set on the last record caused by one input beat.
// A record shows on the master side in the cycle after the byte that ends
// the token is accepted.
// Throughput: one byte per cycle while the receiver takes records. A byte
// that closes a run and is itself an operator, or end of input with a run
// pending, makes two records; the second drains from a two-entry output
// buffer and holds s_axis_tready low until the first record is taken.
// s_axis_tready is high when the output buffer is empty or its one record
// is taken in the same cycle. A stalled receiver leaves records in the
// buffer and input is held off until they drain; nothing is dropped.
// Reset clears the scan state (offset 0, no token pending) and empties the
// output buffer. End of input also returns the scanner to that state, so
// the next byte starts a new source at offset 0.
module keyword_token_lexer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [7:0]                             s_axis_tdata,  // [7:0] source_byte
  input  logic                                   s_axis_tlast,  // end_of_input
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // token_kind[3:0], keyword_code[5:4], start_position[37:6],
  // token_length[53:38], zero fill above
  output logic [kwlex_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
  output logic                                   m_axis_tlast   // last_of_run
);
  import kwlex_pkg::*;

  scan_state_t state_q, state_d;
  token_rec_t  rec0, rec1;
  token_rec_t  head_q, head_d, tail_q, tail_d;
  logic [1:0]  num_rec;
  logic [1:0]  cnt_q, cnt_d;
  logic        in_beat, out_beat;
  logic [REC_BITS-1:0] rec_bits;

  assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  kwlex_step u_step (
    .state_i   (state_q),
    .byte_i    (s_axis_tdata),
    .eoi_i     (s_axis_tlast),
    .state_o   (state_d),
    .num_rec_o (num_rec),
    .rec0_o    (rec0),
    .rec1_o    (rec1)
  );

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (in_beat) begin
      // buffer is empty by the end of this cycle whenever a byte is taken
      head_d = rec0;
      tail_d = rec1;
      cnt_d  = num_rec;
    end else if (out_beat) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= 2'd0;
    end else begin
      if (in_beat) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign rec_bits     = {head_q.len, head_q.start, head_q.kw, head_q.kind};
  assign m_axis_tdata = OUT_TDATA_WIDTH'(rec_bits);
  assign m_axis_tlast = head_q.last;

endmodule

/* design/kwlex_step.sv */
module kwlex_step (
  input  kwlex_pkg::scan_state_t state_i,
  input  logic [7:0]             byte_i,
  input  logic                   eoi_i,
  output kwlex_pkg::scan_state_t state_o,
  output logic [1:0]             num_rec_o,
  output kwlex_pkg::token_rec_t  rec0_o,
  output kwlex_pkg::token_rec_t  rec1_o
);
  import kwlex_pkg::*;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  logic                    is_letter, is_digit, is_op, has_pend;
  kind_e                   op_kind;
  logic [LENGTH_WIDTH-1:0] count_inc;
  token_rec_t              pend_rec, op_rec, eof_rec;

  assign is_letter = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                     (byte_i >= 8'h41 && byte_i <= 8'h5A);
  assign is_digit  = (byte_i >= 8'h30 && byte_i <= 8'h39);
  assign count_inc = (&state_i.count) ? state_i.count
                                      : state_i.count + LENGTH_WIDTH'(1);
  assign has_pend  = (state_i.mode == MODE_WORD) || (state_i.mode == MODE_NUM);

  always_comb begin
    is_op   = 1'b1;
    op_kind = KIND_LPAREN;
    case (byte_i)
      CH_LPAREN: op_kind = KIND_LPAREN;
      CH_RPAREN: op_kind = KIND_RPAREN;
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_SLASH:  op_kind = KIND_SLASH;
      CH_STAR:   op_kind = KIND_STAR;
      default:   is_op = 1'b0;
    endcase
  end

  // record for the letter or digit run in progress
  always_comb begin
    pend_rec       = '0;
    pend_rec.start = state_i.start;
    pend_rec.len   = state_i.count;
    pend_rec.kw    = KW_DO;
    if (state_i.mode == MODE_NUM) begin
      pend_rec.kind = KIND_NUMBER;
    end else begin
      pend_rec.kind = KIND_KEYWORD;
      if (state_i.count == LENGTH_WIDTH'(2) && state_i.prefix == PREFIX_DO) begin
        pend_rec.kw = KW_DO;
      end else if (state_i.count == LENGTH_WIDTH'(3) && state_i.prefix == PREFIX_END) begin
        pend_rec.kw = KW_END;
      end else if (state_i.count == LENGTH_WIDTH'(4) && state_i.prefix == PREFIX_FUNC) begin
        pend_rec.kw = KW_FUNC;
      end else if (state_i.count == LENGTH_WIDTH'(4) && state_i.prefix == PREFIX_EXIT) begin
        pend_rec.kw = KW_EXIT;
      end else begin
        pend_rec.kind = KIND_IDENT;
      end
    end
  end

  always_comb begin
    op_rec       = '0;
    op_rec.kind  = op_kind;
    op_rec.kw    = KW_DO;
    op_rec.start = state_i.pos;
    op_rec.len   = LENGTH_WIDTH'(1);
    eof_rec       = '0;
    eof_rec.kind  = KIND_EOF;
    eof_rec.kw    = KW_DO;
    eof_rec.start = state_i.pos;
  end

  always_comb begin
    state_o   = state_i;
    num_rec_o = 2'd0;
    rec0_o    = pend_rec;
    rec1_o    = op_rec;
    if (eoi_i) begin
      state_o = '0;
      if (state_i.mode == MODE_STR) begin
        rec0_o.kind = KIND_UNTERM;
        rec0_o.kw   = KW_DO;
        num_rec_o   = 2'd1;
      end else if (has_pend) begin
        rec1_o    = eof_rec;
        num_rec_o = 2'd2;
      end else begin
        rec0_o    = eof_rec;
        num_rec_o = 2'd1;
      end
    end else begin
      state_o.pos = state_i.pos + POSITION_WIDTH'(1);
      if (state_i.mode == MODE_STR) begin
        if (byte_i == CH_QUOTE) begin
          rec0_o.kind   = KIND_STRING;
          rec0_o.kw     = KW_DO;
          num_rec_o     = 2'd1;
          state_o.mode  = MODE_IDLE;
        end else begin
          state_o.count = count_inc;
        end
      end else if (state_i.mode == MODE_WORD && is_letter) begin
        if (state_i.count < LENGTH_WIDTH'(4)) begin
          state_o.prefix = {state_i.prefix[23:0], byte_i};
        end
        state_o.count = count_inc;
      end else if (state_i.mode == MODE_NUM && is_digit) begin
        state_o.count = count_inc;
      end else begin
        // anything else ends the run in progress; an operator, letter, digit or quote then starts its own token
        state_o.mode = MODE_IDLE;
        if (is_op) begin
          if (has_pend) begin
            num_rec_o = 2'd2;
          end else begin
            rec0_o    = op_rec;
            num_rec_o = 2'd1;
          end
        end else begin
          num_rec_o = has_pend ? 2'd1 : 2'd0;
          if (is_letter) begin
            state_o.mode   = MODE_WORD;
            state_o.start  = state_i.pos;
            state_o.count  = LENGTH_WIDTH'(1);
            state_o.prefix = {24'd0, byte_i};
          end else if (is_digit) begin
            state_o.mode  = MODE_NUM;
            state_o.start = state_i.pos;
            state_o.count = LENGTH_WIDTH'(1);
          end else if (byte_i == CH_QUOTE) begin
            state_o.mode  = MODE_STR;
            state_o.start = state_i.pos + POSITION_WIDTH'(1);
            state_o.count = '0;
          end
        end
      end
    end
    rec0_o.last = (num_rec_o == 2'd1);
    rec1_o.last = 1'b1;
  end

endmodule
